@@ hw/rtl/jvs_pkg.sv @@
// Shared types, constants and table functions of the joint velocity and gripper controller.
`default_nettype none

package jvs_pkg;

	localparam int FRAC_BITS_DEFAULT     = 12;
	localparam int TANH_SEGMENTS_DEFAULT = 64;
	localparam int QUEUE_DEPTH           = 2;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	localparam logic [15:0] GAIN_KP_RESET            = 16'd256;
	localparam logic [14:0] OMEGA_LIMIT_RESET        = 15'd819;
	localparam logic [14:0] POSITION_TOLERANCE_RESET = 15'd164;
	localparam logic [14:0] VELOCITY_TOLERANCE_RESET = 15'd41;
	localparam logic [23:0] SETTLE_TIME_US_RESET     = 24'd500000;

	typedef enum logic [2:0] {
		CFG_GAIN_KP            = 3'd0,
		CFG_OMEGA_LIMIT        = 3'd1,
		CFG_POSITION_TOLERANCE = 3'd2,
		CFG_VELOCITY_TOLERANCE = 3'd3,
		CFG_SETTLE_TIME_US     = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		GRIP_OPEN    = 2'd0,
		GRIP_GRASP   = 2'd1,
		GRIP_RELEASE = 2'd2
	} gripper_mode_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEG,
		B_LERP,
		B_BLEND,
		B_SCALE
	} back_state_t;

	typedef struct packed {
		logic [15:0] gain_kp;
		logic [14:0] omega_limit;
		logic [14:0] position_tolerance;
		logic [14:0] velocity_tolerance;
		logic [23:0] settle_time_us;
	} cfg_t;

	// One classified joint sample on its way from the front to the back.
	typedef struct packed {
		logic [2:0]    joint_index;
		logic [15:0]   abs_error;
		logic          error_neg;
		logic          target_reached;
		logic          grasp_command;
		logic          release_command;
		gripper_mode_t gripper_phase;
	} job_t;

	// Unsigned quotient of two constants by restoring long division.
	function automatic longint unsigned quotient(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r    = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Decay factor e^(-16/S) in Q30 from a truncated alternating series.
	function automatic longint unsigned tanh_decay(longint unsigned step);
		longint unsigned term;
		longint          sum;
		term = ONE_Q30;
		sum  = longint'(ONE_Q30);
		for (int n = 1; n <= 24; n++) begin
			term = (term * step) >> 30;
			term = quotient(term, 64'(n));
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return (sum > 0) ? longint'(sum) : 64'd0;
	endfunction

	// Table entry k: (1 - u) / (1 + u) with u = decay^k, rounded half up.
	function automatic longint unsigned tanh_entry(int k, longint unsigned decay, int frac);
		longint unsigned u;
		longint unsigned den;
		u = ONE_Q30;
		for (int j = 0; j < k; j++) begin
			u = (u * decay + (ONE_Q30 >> 1)) >> 30;
		end
		den = ONE_Q30 + u;
		return quotient(((ONE_Q30 - u) << frac) + (den >> 1), den);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/joint_velocity_settle_gripper_ctrl.sv @@
// Top level of the joint velocity controller with settle detection and gripper sequencing.
//
// Channel  Direction  Handshake                     Contents
// s_axis   in         s_axis_tvalid/s_axis_tready   one joint sample, tlast ends a tick
// m_axis   out        m_axis_tvalid/m_axis_tready   one velocity command and gripper status
// cfg      in         cfg_valid/cfg_ready           register index and write data
//
// Each request yields one result. The back end runs one request at a time through its
// segment, table lookup, blend and scale steps and takes no new one from the queue before
// the scale step has loaded the output register, so it cannot start a request before the last
// is done. The front end accepts a request per cycle until the two-entry queue fills. The output
// register holds a result under stall while new requests keep entering until the queue fills.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none

module joint_velocity_settle_gripper_ctrl #(
	parameter int FRAC_BITS     = jvs_pkg::FRAC_BITS_DEFAULT,
	parameter int TANH_SEGMENTS = jvs_pkg::TANH_SEGMENTS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// joint_index, joint_position, joint_velocity, target_position, tick_period_us,
	// release_request, then zero fill
	input  wire logic [71:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_joint_index, velocity_command, target_reached, grasp_command, release_command,
	// gripper_phase
	output logic [23:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	jvs_pkg::cfg_t cfg_q;
	jvs_pkg::job_t push_data;
	jvs_pkg::job_t q_head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_kp            <= jvs_pkg::GAIN_KP_RESET;
			cfg_q.omega_limit        <= jvs_pkg::OMEGA_LIMIT_RESET;
			cfg_q.position_tolerance <= jvs_pkg::POSITION_TOLERANCE_RESET;
			cfg_q.velocity_tolerance <= jvs_pkg::VELOCITY_TOLERANCE_RESET;
			cfg_q.settle_time_us     <= jvs_pkg::SETTLE_TIME_US_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jvs_pkg::CFG_GAIN_KP:            cfg_q.gain_kp <= cfg_data[15:0];
				jvs_pkg::CFG_OMEGA_LIMIT:        cfg_q.omega_limit <= cfg_data[14:0];
				jvs_pkg::CFG_POSITION_TOLERANCE: cfg_q.position_tolerance <= cfg_data[14:0];
				jvs_pkg::CFG_VELOCITY_TOLERANCE: cfg_q.velocity_tolerance <= cfg_data[14:0];
				jvs_pkg::CFG_SETTLE_TIME_US:     cfg_q.settle_time_us <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	jvs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.push          (push),
		.push_data     (push_data),
		.q_full        (q_full)
	);

	jvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	jvs_back #(
		.FRAC_BITS     (FRAC_BITS),
		.TANH_SEGMENTS (TANH_SEGMENTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

@@ hw/rtl/jvs_queue.sv @@
// Short job queue between the front and the back.
`default_nettype none

module jvs_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire jvs_pkg::job_t push_data,
	output logic              full,
	input  wire logic         pop,
	output jvs_pkg::job_t     head,
	output logic              empty
);

	localparam int DEPTH = jvs_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	jvs_pkg::job_t  slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job queue read while empty");

endmodule

`default_nettype wire

@@ hw/rtl/jvs_front.sv @@
// Front end: takes joint samples, judges settling and sequences the gripper.
`default_nettype none

module jvs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jvs_pkg::cfg_t cfg,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [71:0]   s_axis_tdata,
	input  wire logic          s_axis_tlast,
	output logic               push,
	output jvs_pkg::job_t      push_data,
	input  wire logic          q_full
);

	logic                  s1_valid_s1;
	logic [2:0]            joint_index_s1;
	logic [15:0]           abs_error_s1;
	logic                  error_neg_s1;
	logic [15:0]           abs_velocity_s1;
	logic [15:0]           tick_period_s1;
	logic                  release_request_s1;
	logic                  last_joint_s1;

	logic [15:0]           max_err_q;
	logic [15:0]           max_vel_q;
	logic [23:0]           timer_q;
	logic                  reached_q;
	logic                  grasp_issued_q;
	logic                  release_pending_q;
	logic                  release_issued_q;
	jvs_pkg::gripper_mode_t mode_q;

	logic [15:0]           max_err_d;
	logic [15:0]           max_vel_d;
	logic [23:0]           timer_d;
	logic                  reached_d;
	logic                  grasp_issued_d;
	logic                  release_pending_d;
	logic                  release_issued_d;
	jvs_pkg::gripper_mode_t mode_d;
	logic                  grasp_pulse;
	logic                  release_pulse;
	logic                  settled;
	logic [24:0]           timer_sum;
	logic [23:0]           timer_sat;

	logic [15:0]           in_position;
	logic [15:0]           in_velocity;
	logic [15:0]           in_target;
	logic [16:0]           err_wide;
	logic [16:0]           err_abs;
	logic [16:0]           vel_wide;
	logic [16:0]           vel_abs;
	logic                  accept;

	assign in_position = s_axis_tdata[18:3];
	assign in_velocity = s_axis_tdata[34:19];
	assign in_target   = s_axis_tdata[50:35];
	assign err_wide    = {in_target[15], in_target} - {in_position[15], in_position};
	assign err_abs     = err_wide[16] ? (17'd0 - err_wide) : err_wide;
	assign vel_wide    = {in_velocity[15], in_velocity};
	assign vel_abs     = vel_wide[16] ? (17'd0 - vel_wide) : vel_wide;

	assign push          = s1_valid_s1 && !q_full;
	assign s_axis_tready = !s1_valid_s1 || push;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (push) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			joint_index_s1     <= s_axis_tdata[2:0];
			abs_error_s1       <= err_abs[15:0];
			error_neg_s1       <= err_wide[16];
			abs_velocity_s1    <= vel_abs[15:0];
			tick_period_s1     <= s_axis_tdata[66:51];
			release_request_s1 <= s_axis_tdata[67];
			last_joint_s1      <= s_axis_tlast;
		end
	end

	// The running maxima stay below tolerance only if both the stored maximum
	// and the current sample do, so the tick is judged with parallel compares.
	always_comb begin
		settled = max_err_q < {1'b0, cfg.position_tolerance}
			&& abs_error_s1 < {1'b0, cfg.position_tolerance}
			&& max_vel_q < {1'b0, cfg.velocity_tolerance}
			&& abs_velocity_s1 < {1'b0, cfg.velocity_tolerance};
		timer_sum = {1'b0, timer_q} + {9'd0, tick_period_s1};
		timer_sat = timer_sum[24] ? 24'hFFFFFF : timer_sum[23:0];

		max_err_d         = (abs_error_s1 > max_err_q) ? abs_error_s1 : max_err_q;
		max_vel_d         = (abs_velocity_s1 > max_vel_q) ? abs_velocity_s1 : max_vel_q;
		timer_d           = timer_q;
		reached_d         = reached_q;
		release_pending_d = release_pending_q || release_request_s1;
		grasp_issued_d    = grasp_issued_q;
		release_issued_d  = release_issued_q;
		mode_d            = mode_q;
		grasp_pulse       = 1'b0;
		release_pulse     = 1'b0;

		if (last_joint_s1) begin
			max_err_d = '0;
			max_vel_d = '0;
			if (settled) begin
				timer_d = timer_sat;
				if (timer_sat > cfg.settle_time_us) begin
					reached_d = 1'b1;
				end
			end else begin
				timer_d = '0;
			end

			if (reached_d) begin
				unique case (mode_q)
					jvs_pkg::GRIP_OPEN: begin
						if (!grasp_issued_q) begin
							grasp_pulse    = 1'b1;
							grasp_issued_d = 1'b1;
							mode_d         = jvs_pkg::GRIP_GRASP;
						end
					end
					jvs_pkg::GRIP_GRASP: begin
						if (release_pending_d) begin
							mode_d = jvs_pkg::GRIP_RELEASE;
						end
					end
					jvs_pkg::GRIP_RELEASE: begin
						if (release_pending_d && !release_issued_q) begin
							release_pulse    = 1'b1;
							release_issued_d = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		push_data.joint_index     = joint_index_s1;
		push_data.abs_error       = abs_error_s1;
		push_data.error_neg       = error_neg_s1;
		push_data.target_reached  = reached_d;
		push_data.grasp_command   = grasp_pulse;
		push_data.release_command = release_pulse;
		push_data.gripper_phase   = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_err_q         <= '0;
			max_vel_q         <= '0;
			timer_q           <= '0;
			reached_q         <= 1'b0;
			grasp_issued_q    <= 1'b0;
			release_pending_q <= 1'b0;
			release_issued_q  <= 1'b0;
			mode_q            <= jvs_pkg::GRIP_OPEN;
		end else if (push) begin
			max_err_q         <= max_err_d;
			max_vel_q         <= max_vel_d;
			timer_q           <= timer_d;
			reached_q         <= reached_d;
			grasp_issued_q    <= grasp_issued_d;
			release_pending_q <= release_pending_d;
			release_issued_q  <= release_issued_d;
			mode_q            <= mode_d;
		end
	end

	a_reached_sticky: assert property (@(posedge clk) disable iff (!arst_n) !$fell(reached_q))
		else $error("target reached flag cleared after latching");
	a_grasp_needs_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.grasp_command) |-> (push_data.target_reached && !grasp_issued_q))
		else $error("grasp command without settled target or issued twice");

endmodule

`default_nettype wire

@@ hw/rtl/jvs_back.sv @@
// Back end: computes the tanh-shaped velocity command and holds the result register.
`default_nettype none

module jvs_back #(
	parameter int FRAC_BITS     = jvs_pkg::FRAC_BITS_DEFAULT,
	parameter int TANH_SEGMENTS = jvs_pkg::TANH_SEGMENTS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jvs_pkg::cfg_t cfg,
	input  wire logic          q_empty,
	input  wire jvs_pkg::job_t q_head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [23:0]        m_axis_tdata
);

	localparam int SPAN_W = FRAC_BITS + 3;
	localparam int KW     = $clog2(TANH_SEGMENTS + 1);
	localparam int TW     = FRAC_BITS + 1;
	localparam int PW     = SPAN_W + KW;
	localparam int BW     = TW + SPAN_W;
	localparam int SW     = 15 + TW;

	localparam longint unsigned TANH_STEP  = (64'd16 << 30) / TANH_SEGMENTS;
	localparam longint unsigned TANH_DECAY = jvs_pkg::tanh_decay(TANH_STEP);
	localparam logic [KW-1:0]   SEG_LAST   = KW'(TANH_SEGMENTS);

	logic [TW-1:0] tanh_rom [TANH_SEGMENTS + 1];

	for (genvar k = 0; k <= TANH_SEGMENTS; k++) begin : g_tanh
		localparam logic [TW-1:0] ENTRY = TW'(jvs_pkg::tanh_entry(k, TANH_DECAY, FRAC_BITS));
		assign tanh_rom[k] = ENTRY;
	end

	jvs_pkg::back_state_t state_q;
	jvs_pkg::back_state_t state_d;
	jvs_pkg::job_t        job_q;
	logic [23:0]          arg_q;
	logic [KW-1:0]        k_q;
	logic [SPAN_W-1:0]    f_q;
	logic [TW-1:0]        t0_q;
	logic [TW-1:0]        diff_q;
	logic [TW-1:0]        value_q;
	logic                 out_load;

	logic [31:0]          gain_prod;
	logic                 arg_sat;
	logic [PW-1:0]        seg_prod;
	logic [KW-1:0]        k_next;
	logic [BW-1:0]        blend_prod;
	logic [SW-1:0]        scale_prod;
	logic [15:0]          mag;
	logic [15:0]          command;

	assign gain_prod  = 32'(q_head.abs_error) * 32'(cfg.gain_kp);
	assign arg_sat    = |arg_q[23:SPAN_W];
	assign seg_prod   = PW'(arg_q[SPAN_W-1:0]) * PW'(TANH_SEGMENTS);
	assign k_next     = (k_q == SEG_LAST) ? k_q : k_q + KW'(1);
	assign blend_prod = BW'(diff_q) * BW'(f_q);
	assign scale_prod = SW'(cfg.omega_limit) * SW'(value_q);
	assign mag        = {1'b0, scale_prod[FRAC_BITS+14:FRAC_BITS]};
	assign command    = job_q.error_neg ? (16'd0 - mag) : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jvs_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			jvs_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = jvs_pkg::B_SEG;
				end
			end
			jvs_pkg::B_SEG:   state_d = jvs_pkg::B_LERP;
			jvs_pkg::B_LERP:  state_d = jvs_pkg::B_BLEND;
			jvs_pkg::B_BLEND: state_d = jvs_pkg::B_SCALE;
			jvs_pkg::B_SCALE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					if (!q_empty) begin
						pop     = 1'b1;
						state_d = jvs_pkg::B_SEG;
					end else begin
						state_d = jvs_pkg::B_IDLE;
					end
				end
			end
			default: state_d = jvs_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
			arg_q <= gain_prod[31:8];
		end
		case (state_q)
			jvs_pkg::B_SEG: begin
				k_q <= arg_sat ? SEG_LAST : seg_prod[PW-1:SPAN_W];
				f_q <= arg_sat ? '0 : seg_prod[SPAN_W-1:0];
			end
			jvs_pkg::B_LERP: begin
				t0_q   <= tanh_rom[k_q];
				diff_q <= tanh_rom[k_next] - tanh_rom[k_q];
			end
			jvs_pkg::B_BLEND: begin
				value_q <= t0_q + blend_prod[BW-1:SPAN_W];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {job_q.gripper_phase, job_q.release_command, job_q.grasp_command,
				job_q.target_reached, command, job_q.joint_index};
		end
	end

endmodule

`default_nettype wire
